// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the run encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define AST_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define AST_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- hdl/srre_pkg.sv -----
// ----------------------------------------------------------------------------
// srre_pkg
// Types and constants shared by the scanline run encoder modules.
// ----------------------------------------------------------------------------
package srre_pkg;

    localparam int PIXEL_BITS = 32;
    localparam int WIDTH_BITS = 4;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;

    localparam logic [7:0] HEADER_BASE = 8'd127;
    localparam logic [7:0] RUN_LIMIT   = 8'd128;
    localparam logic [7:0] BYTE_ONES   = 8'd255;

    // One run packet waiting to be serialized.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic [7:0]            header;
        logic [WIDTH_BITS-1:0] width;
        logic                  item_last;
        logic                  line_last;
    } t_pkt;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- hdl/srre_front.sv -----
// ----------------------------------------------------------------------------
// srre_front
// Accepts pixels, tracks the open run and issues run packets to the queue.
// ----------------------------------------------------------------------------
module srre_front
    import srre_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [2:0]            i_bpp,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic                  i_line_end,
    input  t_q_stat               i_q_stat,
    output logic                  o_push,
    output t_pkt                  o_pkt
);

    localparam int NB = (MAX_PIXEL_BYTES < 4) ? MAX_PIXEL_BYTES : 4;

    logic [PIXEL_BITS-1:0] r_run_pixel, n_run_pixel;
    logic [7:0]            r_run_len, n_run_len;
    logic                  r_pend_valid, n_pend_valid;
    t_pkt                  r_pend, n_pend;

    logic [WIDTH_BITS-1:0] w;
    logic [PIXEL_BITS-1:0] mask;
    logic [PIXEL_BITS-1:0] p;
    logic                  accept;
    logic                  close_old;
    logic                  start;
    logic                  close_new;
    logic [7:0]            len_new;
    t_pkt                  pkt_old, pkt_new;

    always_comb begin
        if (i_bpp == 3'd0) begin
            w = WIDTH_BITS'(1);
        end else if (int'(i_bpp) > MAX_PIXEL_BYTES) begin
            w = WIDTH_BITS'(MAX_PIXEL_BYTES);
        end else begin
            w = WIDTH_BITS'(i_bpp);
        end
    end

    always_comb begin
        mask = '0;
        for (int k = 0; k < NB; k++) begin
            mask[8*k +: 8] = (WIDTH_BITS'(k) < w) ? BYTE_ONES : 8'd0;
        end
    end

    assign p         = i_pixel & mask;
    assign o_ready   = !r_pend_valid && !i_q_stat.full;
    assign accept    = i_valid && o_ready;
    assign close_old = (r_run_len != 8'd0) && ((r_run_pixel & mask) != p);
    assign start     = close_old || (r_run_len == 8'd0);
    assign len_new   = start ? 8'd1 : r_run_len + 8'd1;
    assign close_new = (len_new == RUN_LIMIT) || i_line_end;

    // An end of line always closes the new run, so the old packet never
    // carries the line mark.
    always_comb begin
        pkt_old.pixel     = r_run_pixel;
        pkt_old.header    = HEADER_BASE + r_run_len;
        pkt_old.width     = w;
        pkt_old.item_last = !close_new;
        pkt_old.line_last = 1'b0;

        pkt_new.pixel     = start ? p : r_run_pixel;
        pkt_new.header    = HEADER_BASE + len_new;
        pkt_new.width     = w;
        pkt_new.item_last = 1'b1;
        pkt_new.line_last = i_line_end;
    end

    always_comb begin
        if (r_pend_valid) begin
            o_push = !i_q_stat.full;
            o_pkt  = r_pend;
        end else begin
            o_push = accept && (close_old || close_new);
            o_pkt  = close_old ? pkt_old : pkt_new;
        end
    end

    always_comb begin
        n_run_pixel  = r_run_pixel;
        n_run_len    = r_run_len;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (r_pend_valid && !i_q_stat.full) begin
            n_pend_valid = 1'b0;
        end
        if (accept) begin
            n_run_pixel = pkt_new.pixel;
            n_run_len   = close_new ? 8'd0 : len_new;
            if (close_old && close_new) begin
                n_pend_valid = 1'b1;
                n_pend       = pkt_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_pixel  <= '0;
            r_run_len    <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_run_pixel  <= n_run_pixel;
            r_run_len    <= n_run_len;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

// ----- hdl/srre_queue.sv -----
// ----------------------------------------------------------------------------
// srre_queue
// Short packet queue between the run tracker and the byte serializer.
// ----------------------------------------------------------------------------
module srre_queue
    import srre_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_pkt    i_pkt,
    input  logic    i_pop,
    output t_pkt    o_pkt,
    output t_q_stat o_stat
);

    t_pkt            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_AW:0]   r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_pkt        = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + Q_AW'(1);
        end
        if (i_pop) begin
            n_rp = r_rp + Q_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (Q_AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pkt;
        end
    end

endmodule

// ----- hdl/srre_back.sv -----
// ----------------------------------------------------------------------------
// srre_back
// Turns run packets into header and pixel bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module srre_back
    import srre_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pkt       i_pkt,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_item_last,
    output logic       o_line_last
);

    localparam int NB = (MAX_PIXEL_BYTES < 4) ? MAX_PIXEL_BYTES : 4;
    localparam int IW = $clog2(MAX_PIXEL_BYTES + 1);

    t_pkt          r_pkt;
    logic          r_busy, n_busy;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_item_last;
    logic          r_out_line_last;

    logic          load_ok;
    logic          last_byte;
    logic          finishing;
    logic [7:0]    cur_byte;

    assign load_ok   = !r_out_valid || i_ready;
    assign last_byte = (r_idx == IW'(r_pkt.width));
    assign finishing = r_busy && load_ok && last_byte;
    assign o_pop     = !i_q_stat.empty && (!r_busy || finishing);

    // Index zero is the header; index k+1 is pixel byte k, zero above 32 bits.
    always_comb begin
        cur_byte = 8'd0;
        if (r_idx == '0) begin
            cur_byte = r_pkt.header;
        end
        for (int k = 0; k < NB; k++) begin
            if (r_idx == IW'(k + 1)) begin
                cur_byte = r_pkt.pixel[8*k +: 8];
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (finishing) begin
            n_busy = 1'b0;
        end else if (r_busy && load_ok) begin
            n_idx = r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (load_ok) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pkt <= i_pkt;
        end
        if (load_ok) begin
            r_out_byte      <= cur_byte;
            r_out_item_last <= r_pkt.item_last && last_byte;
            r_out_line_last <= r_pkt.line_last && last_byte;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_byte      = r_out_byte;
    assign o_item_last = r_out_item_last;
    assign o_line_last = r_out_line_last;

endmodule

// ----- hdl/scanline_repeat_run_encoder_unit.sv -----
// Path: a closing pixel's packet passes the queue and the packet register, and its header
// byte passes the output register. Throughput: one output byte per cycle while m_axis_tready
// is high and packets are queued. A packet is 1 + bytes_per_pixel bytes; a pixel that closes two
// runs issues two packets. Pixels that only extend a run are taken at one per cycle while the
// queue has room and no second packet is pending. Reset (synchronous, active low) clears the
// open run, the queue and the output register, and sets bytes_per_pixel to 4.
// ----------------------------------------------------------------------------
// scanline_repeat_run_encoder_unit
// Run-length encoder for one scanline: run packets of a header and pixel bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scanline_repeat_run_encoder_unit
    import srre_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Pixel request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] pixel_value
    input  logic        s_axis_tlast,   // line_end
    // Encoded byte stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] item_last
    output logic        m_axis_tlast    // line_last
);

    logic [2:0] r_bpp;
    logic       cfg_wr;
    logic       q_push;
    logic       q_pop;
    t_pkt       q_in_pkt;
    t_pkt       q_out_pkt;
    t_q_stat    q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {29'd0, r_bpp} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp <= 3'd4;
        end else if (cfg_wr) begin
            r_bpp <= pwdata[2:0];
        end
    end

    srre_front #(
        .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bpp      (r_bpp),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_pixel    (s_axis_tdata),
        .i_line_end (s_axis_tlast),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_pkt      (q_in_pkt)
    );

    srre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pkt   (q_in_pkt),
        .i_pop   (q_pop),
        .o_pkt   (q_out_pkt),
        .o_stat  (q_stat)
    );

    srre_back #(
        .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt       (q_out_pkt),
        .i_q_stat    (q_stat),
        .o_pop       (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_item_last (m_axis_tuser),
        .o_line_last (m_axis_tlast)
    );

    // The line mark only ever lands on the final byte of a request.
    `AST_IMPL(a_line_implies_item, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
    // The queue is never written while full nor read while empty.
    `AST_IMPL(a_no_overflow, i_clk, i_rst_n, q_push, !q_stat.full)
    `AST_IMPL(a_no_underflow, i_clk, i_rst_n, q_pop, !q_stat.empty)
    // An end-of-line pixel always leaves at least one packet queued.
    `AST_NEXT(a_eol_queues, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !q_stat.empty)

endmodule

// ----- tb/run_packet_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_packet_checker
// Watches the register port and both streams of the scanline run encoder,
// rebuilds the expected run packets for every accepted pixel and compares
// each encoded byte against them in order.
// ----------------------------------------------------------------------------
module run_packet_checker #(
    parameter logic [2:0] REG_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] pixel_value
    input  logic        s_axis_tlast,   // line_end
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    input  logic        m_axis_tuser,   // [0] item_last
    input  logic        m_axis_tlast,   // line_last
    output int          o_fail_count,
    output int          o_pending,
    output int          o_byte_count
);

    localparam int unsigned MAX_PIXEL_BYTES = 4;
    localparam logic [7:0]  HEADER_BASE     = 8'd127;
    localparam logic [7:0]  RUN_LIMIT       = 8'd128;

    typedef struct packed {
        logic [7:0] code;
        logic       item_end;
        logic       line_end;
    } t_encoded_byte;

    t_encoded_byte expected_bytes[$];
    logic [2:0]    width_reg;
    logic [31:0]   open_pixel;
    logic [7:0]    open_count;
    int            fail_total = 0;
    int            byte_total = 0;

    // Queues the header and pixel bytes of the open run and closes it.
    function automatic void flush_run(input int unsigned nbytes);
        t_encoded_byte entry;
        entry = '{code: HEADER_BASE + open_count, item_end: 1'b0, line_end: 1'b0};
        expected_bytes.push_back(entry);
        for (int i = 0; i < nbytes; i++) begin
            entry.code = open_pixel[8*i +: 8];
            expected_bytes.push_back(entry);
        end
        open_count = 8'd0;
    endfunction

    function automatic void encode_pixel(input logic [31:0] px, input logic eol);
        int unsigned nbytes;
        logic [31:0] mask;
        logic [31:0] masked;
        int          before_len;
        int          tail;
        nbytes = (width_reg == 3'd0) ? 1 :
                 (width_reg > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : width_reg;
        mask   = (nbytes >= 4) ? 32'hFFFF_FFFF : (32'd1 << (8 * nbytes)) - 32'd1;
        masked = px & mask;
        before_len = expected_bytes.size();

        if (open_count != 8'd0 && (open_pixel & mask) != masked)
            flush_run(nbytes);
        if (open_count == 8'd0) begin
            open_pixel = masked;
            open_count = 8'd1;
        end else begin
            open_count = open_count + 8'd1;
        end
        if (open_count >= RUN_LIMIT || eol)
            flush_run(nbytes);

        if (expected_bytes.size() > before_len) begin
            tail = expected_bytes.size() - 1;
            expected_bytes[tail].item_end = 1'b1;
            expected_bytes[tail].line_end = eol;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_encoded_byte want;
        if (!i_rst_n) begin
            width_reg  = 3'd4;
            open_pixel = '0;
            open_count = 8'd0;
            expected_bytes.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_ADDR)
                width_reg = pwdata[2:0];
            if (s_axis_tvalid && s_axis_tready)
                encode_pixel(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                byte_total++;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected encoded byte %0h with nothing pending", m_axis_tdata);
                    fail_total++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want.code) begin
                        $error("out_byte: expected %0h, actual %0h", want.code, m_axis_tdata);
                        fail_total++;
                    end
                    if (m_axis_tuser !== want.item_end) begin
                        $error("item_last: expected %0b, actual %0b",
                               want.item_end, m_axis_tuser);
                        fail_total++;
                    end
                    if (m_axis_tlast !== want.line_end) begin
                        $error("line_last: expected %0b, actual %0b",
                               want.line_end, m_axis_tlast);
                        fail_total++;
                    end
                end
            end
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= fail_total;
        o_byte_count <= byte_total;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives pixels and width settings into the scanline run encoder under three
// flow-control patterns and reports the verdict from the packet checker.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [2:0]  ADDR_BYTES_PER_PIXEL = 3'd0;
    localparam int unsigned MAX_BYTES      = 4;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES    = 120;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] pixel_value
    logic        s_axis_tlast  = 1'b0;  // line_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] out_byte
    logic        m_axis_tuser;          // [0] item_last
    logic        m_axis_tlast;          // line_last

    int          fail_count;
    int          pending;
    int          byte_count;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_reqs     = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned idle_cycles   = 0;
    int unsigned pixel_count   = 0;
    int unsigned line_count    = 0;
    int unsigned width_now     = MAX_BYTES;

    scanline_repeat_run_encoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    run_packet_checker #(.REG_ADDR(ADDR_BYTES_PER_PIXEL)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_byte_count  (byte_count)
    );

    always #5 i_clk = ~i_clk;

    // A new hold request from the stimulus starts a long stretch with ready low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_reqs != hold_served) begin
            hold_served   <= hold_reqs;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Valid stays high after an accepted request; the next call either
    // offers new data or drops it for an idle cycle.
    task automatic send_pixel(input logic [31:0] px, input logic eol);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tlast  <= eol;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixel_count++;
        if (eol)
            line_count++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [2:0] w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BYTES_PER_PIXEL;
        pwdata  <= {29'($urandom()), w};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        width_now = (w == 3'd0) ? 1 : (w > MAX_BYTES) ? MAX_BYTES : w;
    endtask

    // Runs share their low pixel bytes; bytes above the width are scrambled.
    task automatic send_scanline(input int unsigned nruns, input bit close);
        logic [31:0] mask;
        logic [31:0] base;
        int unsigned len;
        mask = (width_now >= MAX_BYTES) ? 32'hFFFF_FFFF : (32'd1 << (8 * width_now)) - 32'd1;
        for (int r = 0; r < nruns; r++) begin
            base = $urandom();
            len  = ($urandom_range(19) == 0) ? $urandom_range(20, 6) : $urandom_range(5, 1);
            for (int k = 0; k < len; k++)
                send_pixel((base & mask) | ($urandom() & ~mask),
                           close && r == nruns - 1 && k == len - 1);
        end
    endtask

    initial begin
        int unsigned target;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, starting at the reset width of four bytes.
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'hA5A5_A5A5, 1'b0);
        send_pixel(32'hA5A5_A5A5, 1'b0);
        send_pixel(32'hA5A5_A5A5, 1'b1);
        // A differing pixel that also ends the line sends two packets.
        send_pixel(32'h0102_0304, 1'b0);
        send_pixel(32'h0102_0305, 1'b1);
        // The open run survives a width change and is compared at the new width.
        send_pixel(32'h1122_3344, 1'b0);
        wait_drained();
        write_width(3'd1);
        send_pixel(32'h9999_9944, 1'b1);
        wait_drained();
        write_width(3'd2);
        send_pixel(32'hAAAA_1234, 1'b0);
        send_pixel(32'h5555_1234, 1'b1);
        wait_drained();
        write_width(3'd0);
        send_pixel(32'h0000_00FE, 1'b0);
        send_pixel(32'hFFFF_FF7F, 1'b1);
        wait_drained();
        write_width(3'd7);
        send_pixel(32'h8000_0000, 1'b0);
        send_pixel(32'h8000_0000, 1'b1);
        wait_drained();
        write_width(3'd5);
        send_pixel(32'h7FFF_FFFF, 1'b1);
        wait_drained();
        write_width(3'd6);
        send_pixel(32'h1234_5678, 1'b1);
        wait_drained();
        write_width(3'd3);
        send_pixel(32'hFF00_FF00, 1'b0);
        send_pixel(32'h0000_FF00, 1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 79 : 0;
            recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 6 : 0;
            if (ph == 2) begin
                wait_drained();
                write_width(3'd4);
                // Receiver stalls while distinct pixels keep coming.
                hold_reqs <= hold_reqs + 1;
                for (int k = 0; k < 30; k++)
                    send_pixel($urandom(), k == 29);
                wait_drained();
                // Full-length run, closed at the limit, then a short tail.
                for (int k = 0; k < 130; k++)
                    send_pixel(32'hC0DE_0F0F, k == 129);
            end
            target = pixel_count + ((ph == 2) ? 20 : 95);
            while (pixel_count < target) begin
                if ($urandom_range(3) == 0) begin
                    wait_drained();
                    write_width(3'($urandom_range(7)));
                end
                send_scanline($urandom_range(6, 1), $urandom_range(9) != 0);
            end
        end

        wait_drained();
        $display("Run summary: %0d pixels, %0d closed scanlines, %0d encoded bytes compared.",
                 pixel_count, line_count, byte_count);
        $display("Widths 0 to 7 were programmed under three flow patterns and a long stall.");
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/srre_pkg.sv
hdl/srre_front.sv
hdl/srre_queue.sv
hdl/srre_back.sv
hdl/scanline_repeat_run_encoder_unit.sv
tb/run_packet_checker.sv
tb/tb.sv
